[rtl/mcr_pkg.sv]
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies; the front, queue, back and top rtl files import this package.
package mcr_pkg;

    localparam int unsigned QDepth      = 2;       // job queue entries
    localparam logic [7:0]  RadiusReset = 8'd60;
    localparam logic [2:0]  LastIdx     = 3'd7;    // eighth pixel of a burst

    localparam logic CmdStart = 1'b0;
    localparam logic CmdStep  = 1'b1;

    // One job handed from front to back: a single result or an eight-pixel burst.
    typedef struct packed {
        logic       burst;
        logic       finished;
        logic [9:0] h;
        logic [9:0] k;
        logic [7:0] x;
        logic [7:0] y;
    } t_job;

endpackage

[rtl/mcr_intf.sv]
// Valid/ready channel interfaces for the rasterizer command input and pixel output.
// No dependencies.
interface mcr_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [9:0] center_x;
    logic [9:0] center_y;

    modport source(output valid, output command, output center_x, output center_y,
                   input ready);
    modport sink(input valid, input command, input center_x, input center_y,
                 output ready);
endinterface

interface mcr_out_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] pixel_x;
    logic signed [11:0] pixel_y;
    logic              last;
    logic              finished;

    modport source(output valid, output pixel_x, output pixel_y, output last,
                   output finished, input ready);
    modport sink(input valid, input pixel_x, input pixel_y, input last,
                 input finished, output ready);
endinterface

[rtl/mcr_front.sv]
// Front end: radius register, circle state and decision update, one command per cycle
// while the queue has room. Depends on mcr_pkg and mcr_in_if; emits jobs to the queue.
module mcr_front #(
    parameter int unsigned MAX_RADIUS = 255
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    mcr_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_job_valid,
    output mcr_pkg::t_job o_job
);
    import mcr_pkg::*;

    localparam int unsigned ClampR = (MAX_RADIUS > 255) ? 255 : MAX_RADIUS;
    localparam logic [7:0]  MaxR8  = ClampR[7:0];

    logic [7:0]  r_radius;
    logic [9:0]  r_cc,  n_cc;
    logic [9:0]  r_cr,  n_cr;
    logic [7:0]  r_x,   n_x;
    logic [7:0]  r_y,   n_y;
    logic [11:0] r_d,   n_d;
    logic        r_act, n_act;

    logic               accept;
    logic [7:0]         rad_c;
    logic signed [13:0] d_ext, x14, y14, d_new;
    logic signed [9:0]  x_new, y_new;

    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && !i_q_full;
    assign o_job_valid = accept;

    always_comb begin
        n_cc  = r_cc;
        n_cr  = r_cr;
        n_x   = r_x;
        n_y   = r_y;
        n_d   = r_d;
        n_act = r_act;
        o_job = '0;

        rad_c = (r_radius > MaxR8) ? MaxR8 : r_radius;
        d_ext = {{2{r_d[11]}}, r_d};
        x14   = {6'b0, r_x};
        y14   = {6'b0, r_y};
        x_new = signed'({2'b00, r_x}) + 10'sd1;
        if (r_d[11]) begin
            d_new = d_ext + (x14 <<< 2) + 14'sd6;
            y_new = signed'({2'b00, r_y});
        end else begin
            d_new = d_ext + ((x14 - y14) <<< 2) + 14'sd10;
            y_new = signed'({2'b00, r_y}) - 10'sd1;
        end

        if (i_in.command == CmdStart) begin
            o_job.h = i_in.center_x;
            o_job.k = i_in.center_y;
            n_cc    = i_in.center_x;
            n_cr    = i_in.center_y;
            n_x     = '0;
            n_y     = rad_c;
            n_d     = 12'd3 - {3'b000, rad_c, 1'b0};
            n_act   = 1'b1;
        end else if (!r_act) begin
            o_job.finished = 1'b1;
        end else begin
            o_job.burst = 1'b1;
            o_job.h     = r_cc;
            o_job.k     = r_cr;
            o_job.x     = r_x;
            o_job.y     = r_y;
            // circle done once x passes y; y stops at zero
            if (x_new > y_new) begin
                n_act = 1'b0;
                if (y_new < 10'sd0) begin
                    y_new = '0;
                end
            end
            n_x = x_new[7:0];
            n_y = y_new[7:0];
            n_d = d_new[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RadiusReset;
            r_cc     <= '0;
            r_cr     <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_d      <= '0;
            r_act    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (accept) begin
                r_cc  <= n_cc;
                r_cr  <= n_cr;
                r_x   <= n_x;
                r_y   <= n_y;
                r_d   <= n_d;
                r_act <= n_act;
            end
        end
    end

endmodule

[rtl/mcr_queue.sv]
// Short job queue between front and back ends.
// Depends on mcr_pkg for the job type and depth.
module mcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mcr_pkg::t_job o_job
);
    import mcr_pkg::*;

    localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int unsigned CntW = $clog2(QDepth + 1);

    t_job            r_mem [QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[rtl/mcr_back.sv]
// Back end: walks a job's octant pixels into the output register, one per cycle
// while o_out is not stalled. Depends on mcr_pkg and mcr_out_if.
module mcr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  mcr_pkg::t_job i_job,
    output logic          o_pop,
    mcr_out_if.source     o_out
);
    import mcr_pkg::*;

    logic [2:0]         r_idx, n_idx;
    logic               r_valid;
    logic signed [11:0] r_px, r_py;
    logic               r_last, r_fin;

    logic               load, last_sel;
    logic signed [11:0] h12, k12, x12, y12, px, py;

    assign load     = i_job_valid && (!r_valid || o_out.ready);
    assign last_sel = !i_job.burst || (r_idx == LastIdx);
    assign o_pop    = load && last_sel;

    always_comb begin
        h12 = signed'({2'b00, i_job.h});
        k12 = signed'({2'b00, i_job.k});
        x12 = signed'({4'b0000, i_job.x});
        y12 = signed'({4'b0000, i_job.y});
        unique case (r_idx)
            3'd0: begin px = h12 + x12; py = k12 + y12; end
            3'd1: begin px = h12 + y12; py = k12 + x12; end
            3'd2: begin px = h12 - y12; py = k12 + x12; end
            3'd3: begin px = h12 - x12; py = k12 + y12; end
            3'd4: begin px = h12 + x12; py = k12 - y12; end
            3'd5: begin px = h12 + y12; py = k12 - x12; end
            3'd6: begin px = h12 - x12; py = k12 - y12; end
            default: begin px = h12 - y12; py = k12 - x12; end
        endcase

        n_idx = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (load) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_px   <= px;
            r_py   <= py;
            r_last <= last_sel;
            r_fin  <= i_job.finished;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.pixel_x  = r_px;
    assign o_out.pixel_y  = r_py;
    assign o_out.last     = r_last;
    assign o_out.finished = r_fin;

endmodule

[rtl/midpoint_circle_rasterizer_core.sv]
// Top level of the midpoint circle rasterizer: front end, job queue, back end.
// Depends on mcr_pkg, mcr_intf, mcr_front, mcr_queue and mcr_back.
//
// Usage:
//   i_in carries commands: command 0 starts a circle at (center_x, center_y) with
//   the radius register, command 1 advances one octant step. o_out carries pixels
//   with last marking the final result of a command, finished marking a step
//   given with no circle in progress (pixel fields zero).
//   i_cfg_we / i_cfg_data write the 8-bit radius (reset 60), clamped to
//   MAX_RADIUS at start; write it only while the block is idle.
// Path: an accepted command's job is written into the queue, and the back end
//   then loads its first result from the queue into the o_out output register.
// Throughput: one result per cycle on o_out while o_out.ready is high; a start or
//   idle step gives one result and an octant step eight (back end pixel counter).
//   The front end takes a command every cycle while the two-entry queue has room.
// Reset: synchronous, active low; radius back to 60, no circle active, queue
//   and output register empty.
// Stall: when o_out.ready is low the output register holds, the back end waits,
//   the queue fills and i_in.ready drops once it is full.
module midpoint_circle_rasterizer_core #(
    parameter int unsigned MAX_RADIUS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    mcr_in_if.sink     i_in,
    mcr_out_if.source  o_out
);
    import mcr_pkg::*;

    logic push, full, pop, q_valid;
    t_job job_in, job_out;

    mcr_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_q_full    (full),
        .o_job_valid (push),
        .o_job       (job_in)
    );

    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    mcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("job popped from empty queue");

    a_finished_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.finished) |->
            (o_out.last && o_out.pixel_x == 12'sd0 && o_out.pixel_y == 12'sd0))
        else $error("finished result carries a pixel or is not last");

    a_burst_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.last) |-> !o_out.finished)
        else $error("finished flag inside a pixel burst");

endmodule
